### rtl/core/lzmd_pkg.sv
`default_nettype none
package lzmd_pkg;

	localparam int HISTORY_DEPTH_DEF = 256;
	localparam int BYTES_PER_RESULT  = 4;
	localparam int BYTE_W            = 8;
	localparam int LEN_W             = 32;
	localparam int CNT_W             = $clog2(BYTES_PER_RESULT + 1);
	localparam int IDX_W             = $clog2(BYTES_PER_RESULT);
	localparam int CFG_INDEX_W       = 1;
	localparam int CFG_DATA_W        = 32;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_MARKER = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUTLEN = 1'd1;

	// token phases
	localparam logic [1:0] PH_LIT  = 2'd0;
	localparam logic [1:0] PH_DIST = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;

	// one byte (or an error mark) handed to the packer
	typedef struct packed {
		logic              valid;
		logic              err;
		logic              last;
		logic              limit_hit;
		logic [BYTE_W-1:0] data;
	} push_t;

	typedef struct packed {
		logic busy;
		logic room;
	} pack_status_t;

endpackage
`default_nettype wire

### rtl/core/lzmd_if.sv
`default_nettype none
interface lzmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_start;

	modport source(output valid, output in_byte, output stream_start, input ready);
	modport sink(input valid, input in_byte, input stream_start, output ready);
endinterface

interface lzmd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_a;
	logic [7:0] byte_b;
	logic [7:0] byte_c;
	logic [7:0] byte_d;
	logic [2:0] byte_count;
	logic       run_last;
	logic       stream_done;
	logic       bad_reference;

	modport source(output valid, output byte_a, output byte_b, output byte_c,
		output byte_d, output byte_count, output run_last, output stream_done,
		output bad_reference, input ready);
	modport sink(input valid, input byte_a, input byte_b, input byte_c,
		input byte_d, input byte_count, input run_last, input stream_done,
		input bad_reference, output ready);
endinterface
`default_nettype wire

### rtl/core/lzmd_hist_ram.sv
`default_nettype none
module lzmd_hist_ram #(
	parameter int DEPTH = lzmd_pkg::HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [lzmd_pkg::BYTE_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr,
	output logic      [lzmd_pkg::BYTE_W-1:0] rdata
);

	logic [lzmd_pkg::BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first: a distance-one copy reads the byte being written
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/lzmd_packer.sv
`default_nettype none
module lzmd_packer (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lzmd_pkg::push_t        push,
	output lzmd_pkg::pack_status_t      status,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [lzmd_pkg::BYTE_W-1:0] byte_a,
	output logic [lzmd_pkg::BYTE_W-1:0] byte_b,
	output logic [lzmd_pkg::BYTE_W-1:0] byte_c,
	output logic [lzmd_pkg::BYTE_W-1:0] byte_d,
	output logic [lzmd_pkg::CNT_W-1:0]  byte_count,
	output logic                        run_last,
	output logic                        stream_done,
	output logic                        bad_reference
);

	localparam int BPR = lzmd_pkg::BYTES_PER_RESULT;
	localparam int CW  = lzmd_pkg::CNT_W;
	localparam int IW  = lzmd_pkg::IDX_W;

	logic [lzmd_pkg::BYTE_W-1:0] bytes_q [BPR];
	logic [lzmd_pkg::BYTE_W-1:0] masked [BPR];
	logic [CW-1:0]               cnt_q;
	logic                        last_q;
	logic                        err_q;
	logic                        flush;
	logic [CW-1:0]               cnt_base;
	logic [CW-1:0]               cnt_next;
	logic                        add_byte;

	assign flush    = ((cnt_q == CW'(BPR)) || last_q) && (!out_valid || out_ready);
	assign cnt_base = flush ? '0 : cnt_q;
	assign add_byte = push.valid && !push.err;
	assign cnt_next = cnt_base + CW'(add_byte);

	assign status.busy = (cnt_q != '0) || last_q;
	assign status.room = cnt_next < CW'(BPR);

	always_comb begin
		for (int i = 0; i < BPR; i++) begin
			masked[i] = (CW'(i) < cnt_q) ? bytes_q[i] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (add_byte) begin
			bytes_q[cnt_base[IW-1:0]] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
			err_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (push.valid) begin
				last_q <= push.last;
				err_q  <= push.err;
			end else if (flush) begin
				last_q <= 1'b0;
				err_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (flush) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush) begin
			byte_a        <= masked[0];
			byte_b        <= masked[1];
			byte_c        <= masked[2];
			byte_d        <= masked[3];
			byte_count    <= cnt_q;
			run_last      <= last_q;
			stream_done   <= last_q && push.limit_hit;
			bad_reference <= err_q;
		end
	end

endmodule
`default_nettype wire

### rtl/core/lzmd_ctrl.sv
`default_nettype none
module lzmd_ctrl #(
	parameter int HISTORY_DEPTH = lzmd_pkg::HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(HISTORY_DEPTH)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lzmd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lzmd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [lzmd_pkg::BYTE_W-1:0]     in_byte,
	input  wire logic                            stream_start,
	input  wire lzmd_pkg::pack_status_t          status,
	output lzmd_pkg::push_t                      push,
	output logic                                 ram_we,
	output logic [AW-1:0]                        ram_waddr,
	output logic [lzmd_pkg::BYTE_W-1:0]          ram_wdata,
	output logic                                 ram_re,
	output logic [AW-1:0]                        ram_raddr,
	input  wire logic [lzmd_pkg::BYTE_W-1:0]     ram_rdata
);

	localparam int BW = lzmd_pkg::BYTE_W;
	localparam int LW = lzmd_pkg::LEN_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_COPY = 3'b010,
		ST_ESC  = 3'b100
	} state_t;

	state_t        state_q;
	logic [BW-1:0] marker_q;
	logic [LW-1:0] outlen_q;
	logic [1:0]    phase_q;
	logic [BW-1:0] held_q;
	logic [LW-1:0] produced_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rd_addr_q;
	logic [BW-1:0] remain_q;
	logic [BW-1:0] esc_q;
	logic          rd_valid_s1;
	logic          rd_last_s1;

	logic          accept;
	logic [1:0]    phase_e;
	logic [LW-1:0] prod_e;
	logic          done_e;
	logic [LW-1:0] room_left;
	logic [BW-1:0] eff_dist;
	logic          bad_ref;
	logic [BW-1:0] copy_n;

	assign in_ready = (state_q == ST_IDLE) && !status.busy && !rd_valid_s1;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_e   = stream_start ? lzmd_pkg::PH_LIT : phase_q;
		prod_e    = stream_start ? '0 : produced_q;
		done_e    = prod_e >= outlen_q;
		room_left = outlen_q - prod_e;
		// distances above the marker skip the marker value
		eff_dist  = held_q - BW'(held_q > marker_q);
		bad_ref   = (eff_dist == '0) || (LW'(eff_dist) > prod_e)
			|| (LW'(eff_dist) >= LW'(HISTORY_DEPTH));
		copy_n    = (LW'(in_byte) > room_left) ? room_left[BW-1:0] : in_byte;
	end

	always_comb begin
		push           = '0;
		push.limit_hit = produced_q >= outlen_q;
		if (rd_valid_s1) begin
			push.valid = 1'b1;
			push.data  = ram_rdata;
			push.last  = rd_last_s1;
		end else if (state_q == ST_ESC) begin
			push.valid = 1'b1;
			push.data  = esc_q;
			push.last  = 1'b1;
		end else if (accept && !done_e) begin
			case (phase_e)
				lzmd_pkg::PH_DIST: begin
				end
				lzmd_pkg::PH_LEN: begin
					if (held_q == marker_q) begin
						push.valid = 1'b1;
						push.data  = marker_q;
						push.last  = (in_byte == marker_q) || (room_left == LW'(1));
					end else if (bad_ref) begin
						push.valid = 1'b1;
						push.err   = 1'b1;
						push.last  = 1'b1;
					end
				end
				default: begin
					if (in_byte != marker_q) begin
						push.valid = 1'b1;
						push.data  = in_byte;
						push.last  = 1'b1;
					end
				end
			endcase
		end
	end

	assign ram_we    = push.valid && !push.err;
	assign ram_waddr = wp_q;
	assign ram_wdata = push.data;
	assign ram_re    = (state_q == ST_COPY) && status.room;
	assign ram_raddr = rd_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= '0;
			outlen_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lzmd_pkg::CFG_MARKER: marker_q <= cfg_wdata[BW-1:0];
				lzmd_pkg::CFG_OUTLEN: outlen_q <= cfg_wdata[LW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			wp_q        <= '0;
			produced_q  <= '0;
		end else begin
			rd_valid_s1 <= ram_re;
			rd_last_s1  <= remain_q == BW'(1);
			if (ram_we) begin
				wp_q <= wp_q + AW'(1);
			end
			produced_q <= (accept ? prod_e : produced_q) + LW'(ram_we);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= lzmd_pkg::PH_LIT;
			held_q    <= '0;
			esc_q     <= '0;
			remain_q  <= '0;
			rd_addr_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= phase_e;
						if (!done_e) begin
							case (phase_e)
								lzmd_pkg::PH_DIST: begin
									held_q  <= in_byte;
									phase_q <= lzmd_pkg::PH_LEN;
								end
								lzmd_pkg::PH_LEN: begin
									phase_q <= lzmd_pkg::PH_LIT;
									if (held_q == marker_q) begin
										// escaped marker; a second marker opens a new token
										if (in_byte == marker_q) begin
											phase_q <= lzmd_pkg::PH_DIST;
										end else if (room_left > LW'(1)) begin
											esc_q   <= in_byte;
											state_q <= ST_ESC;
										end
									end else if (!bad_ref && (copy_n != '0)) begin
										remain_q  <= copy_n;
										rd_addr_q <= wp_q - AW'(eff_dist);
										state_q   <= ST_COPY;
									end
								end
								default: begin
									phase_q <= (in_byte == marker_q) ? lzmd_pkg::PH_DIST
										: lzmd_pkg::PH_LIT;
								end
							endcase
						end
					end
				end
				ST_COPY: begin
					if (ram_re) begin
						rd_addr_q <= rd_addr_q + AW'(1);
						remain_q  <= remain_q - BW'(1);
						if (remain_q == BW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ESC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/lz_marker_byte_decompressor.sv
// Marker-byte LZ decompressor: one compressed byte per input transaction, up to four
// decompressed bytes per output transaction, the last of a byte's transactions flagged
// run_last. A literal byte is accepted, then handed off from the packing register to the
// output register; marker and distance bytes are only accepted. A back-reference copy of
// n bytes takes a setup step and then a run set by the single read port of the history
// RAM (one byte per cycle while the packing register has room, registered read), by the
// four-byte packing register draining into the output register, and by the final
// hand-off. The history needs no clearing pass after reset. The user must write
// configuration only while no transaction is in progress; the block does not enforce it.
`default_nettype none
module lz_marker_byte_decompressor #(
	parameter int HISTORY_DEPTH = lzmd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lzmd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lzmd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	lzmd_in_if.sink                               in_ch,
	lzmd_out_if.source                            out_ch
);

	localparam int AW = $clog2(HISTORY_DEPTH);

	lzmd_pkg::push_t               push;
	lzmd_pkg::pack_status_t        status;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [lzmd_pkg::BYTE_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [lzmd_pkg::BYTE_W-1:0]   ram_rdata;

	lzmd_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_byte      (in_ch.in_byte),
		.stream_start (in_ch.stream_start),
		.status       (status),
		.push         (push),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	lzmd_hist_ram #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lzmd_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.status        (status),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.byte_a        (out_ch.byte_a),
		.byte_b        (out_ch.byte_b),
		.byte_c        (out_ch.byte_c),
		.byte_d        (out_ch.byte_d),
		.byte_count    (out_ch.byte_count),
		.run_last      (out_ch.run_last),
		.stream_done   (out_ch.stream_done),
		.bad_reference (out_ch.bad_reference)
	);

endmodule
`default_nettype wire

### rtl/core/lzmd_checker.sv
`default_nettype none
module lzmd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] byte_a,
	input wire logic [7:0] byte_b,
	input wire logic [7:0] byte_c,
	input wire logic [7:0] byte_d,
	input wire logic [2:0] byte_count,
	input wire logic       run_last,
	input wire logic       stream_done,
	input wire logic       bad_reference
);

	localparam logic [2:0] FULL = 3'(lzmd_pkg::BYTES_PER_RESULT);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({byte_a, byte_b, byte_c, byte_d, byte_count,
				run_last, stream_done, bad_reference}))
		else $error("output transaction changed while stalled");

	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_reference |-> byte_count == 3'd0 && run_last
			&& byte_a == 8'd0 && byte_d == 8'd0)
		else $error("error transaction carries bytes or is not last");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_reference |-> byte_count != 3'd0 && byte_count <= FULL)
		else $error("data transaction with bad byte count");

	a_mid_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> byte_count == FULL && !stream_done)
		else $error("non-final transaction not full or flagged done");

endmodule

bind lz_marker_byte_decompressor lzmd_checker u_lzmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.byte_a        (out_ch.byte_a),
	.byte_b        (out_ch.byte_b),
	.byte_c        (out_ch.byte_c),
	.byte_d        (out_ch.byte_d),
	.byte_count    (out_ch.byte_count),
	.run_last      (out_ch.run_last),
	.stream_done   (out_ch.stream_done),
	.bad_reference (out_ch.bad_reference)
);
`default_nettype wire
